### sv/bti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bti_pkg
// Shared types and constants of the bilinear table interpolator.
// ----------------------------------------------------------------------------
package bti_pkg;

    typedef enum logic [2:0] {
        ACT_WR_CL   = 3'd0,
        ACT_WR_TEMP = 3'd1,
        ACT_WR_LIN  = 3'd2,
        ACT_WR_PAR  = 3'd3,
        ACT_EVAL    = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        REG_CL_PERCENT = 2'd0,
        REG_CL_COUNT   = 2'd1,
        REG_TEMP_COUNT = 2'd2
    } t_reg_index;

    localparam logic [16:0]        FRAC_ONE = 17'h10000;
    localparam logic signed [31:0] ONE_Q16  = 32'sh0001_0000;

endpackage
`default_nettype wire

### sv/bilinear_table_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none
// Writes give no result. A disabled evaluate sets a pending result flag, from which
// output valid is raised once the output register is free. A full evaluate runs two
// bracket scans (end compares, scan, 17 divider steps), four grid reads, and a
// multiply/accumulate and rounding pass for each factor before its result is pending.
// Requests stall while an evaluate is in flight.
// Synchronous active-low reset clears state, pending flag, configuration and output valid, not memories.
// ----------------------------------------------------------------------------
// bilinear_table_interpolator
// Breakpoint and grid memories with a sequencer that brackets, divides and
// bilinearly interpolates two factor grids.
// ----------------------------------------------------------------------------
module bilinear_table_interpolator
    import bti_pkg::*;
#(
    parameter int MAX_CL_POINTS   = 16,
    parameter int MAX_TEMP_POINTS = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire  [2:0]         i_action,
    input  wire  [7:0]         i_entry_index,
    input  wire  signed [31:0] i_entry_value,
    input  wire  signed [31:0] i_temperature,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic signed [31:0] o_linear_factor,
    output logic signed [31:0] o_parabolic_factor,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire  [1:0]         i_cfg_index,
    input  wire  [22:0]        i_cfg_data
);

    localparam int GRID_DEPTH = MAX_CL_POINTS * MAX_TEMP_POINTS;
    localparam int CLW = $clog2(MAX_CL_POINTS);
    localparam int TPW = $clog2(MAX_TEMP_POINTS);
    localparam int GW  = $clog2(GRID_DEPTH);
    localparam int IW  = (CLW > TPW) ? CLW : TPW;
    localparam int NW  = IW + 1;
    localparam int BW  = 2 * NW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_LO, S_HI, S_HIC, S_SCAN, S_DIV, S_BDONE, S_ADDR,
        S_GA, S_GB, S_GC, S_GD, S_GE, S_MUL, S_ACC, S_RND
    } t_state;

    t_state r_state;
    logic   r_out_pend;

    // configuration
    logic [22:0] r_cl_percent;
    logic [4:0]  r_cl_count;
    logic [4:0]  r_temp_count;

    // memories
    logic signed [31:0] cl_mem  [MAX_CL_POINTS];
    logic signed [31:0] tp_mem  [MAX_TEMP_POINTS];
    logic signed [31:0] lin_mem [GRID_DEPTH];
    logic signed [31:0] par_mem [GRID_DEPTH];
    logic signed [31:0] r_cl_rd, r_tp_rd, r_lin_rd, r_par_rd;

    // sequencer datapath
    logic               r_ph;
    logic signed [32:0] r_x;
    logic signed [31:0] r_temp;
    logic [NW-1:0]      r_n, r_nt;
    logic [IW-1:0]      r_k, r_idx, r_ic, r_it;
    logic signed [32:0] r_lo;
    logic [16:0]        r_frac, r_s, r_t, r_st;
    logic [32:0]        r_den;
    logic [33:0]        r_rem;
    logic [4:0]         r_dcnt;
    logic [GW-1:0]      r_base0;
    logic signed [31:0] r_lv0, r_lv1, r_lv2, r_lv3, r_pv0, r_pv1, r_pv2, r_pv3;
    logic               r_gsel;
    logic [1:0]         r_term;
    logic signed [51:0] r_prod;
    logic signed [55:0] r_acc;
    logic signed [31:0] r_lin_res, r_par_res;

    logic [NW-1:0]      w_nc, w_nt;
    logic               w_in_acc, w_out_acc, w_disabled;
    logic [IW-1:0]      w_addr, w_nm1, w_nm2;
    logic [GW-1:0]      w_base1, w_gaddr;
    logic signed [32:0] w_bdata;
    logic [33:0]        w_rem_sh;
    logic [BW-1:0]      w_base_full;
    logic [33:0]        w_st_full;
    logic signed [31:0] w_g0, w_g1, w_g2, w_g3;
    logic signed [33:0] w_diff;
    logic [16:0]        w_coef;
    logic signed [39:0] w_rnd;
    logic signed [31:0] w_sat;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE) || r_out_pend;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_acc   = o_out_valid && !i_out_stall;

    always_comb begin
        w_nc = (8'(r_cl_count) > 8'(MAX_CL_POINTS)) ? NW'(MAX_CL_POINTS) : NW'(r_cl_count);
        w_nt = (8'(r_temp_count) > 8'(MAX_TEMP_POINTS)) ?
               NW'(MAX_TEMP_POINTS) : NW'(r_temp_count);
        w_disabled = (r_cl_percent == 23'd0) || (w_nc < NW'(2)) || (w_nt < NW'(2));
    end

    assign w_nm1   = IW'(r_n - NW'(1));
    assign w_nm2   = IW'(r_n - NW'(2));
    assign w_bdata = r_ph ? 33'(r_tp_rd) : 33'(r_cl_rd);

    always_comb begin
        case (r_state)
            S_HI:    w_addr = w_nm1;
            S_HIC:   w_addr = IW'(1);
            S_SCAN:  w_addr = (r_k == w_nm1) ? r_k : r_k + IW'(1);
            default: w_addr = '0;
        endcase
    end

    assign w_base1 = r_base0 + GW'(r_nt);
    always_comb begin
        case (r_state)
            S_GB:    w_gaddr = r_base0 + GW'(1);
            S_GC:    w_gaddr = w_base1;
            S_GD:    w_gaddr = w_base1 + GW'(1);
            default: w_gaddr = r_base0;
        endcase
    end

    // breakpoint memories
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_action == ACT_WR_CL && 9'(i_entry_index) < 9'(MAX_CL_POINTS)) begin
            cl_mem[i_entry_index[CLW-1:0]] <= i_entry_value;
        end
        r_cl_rd <= cl_mem[w_addr[CLW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_action == ACT_WR_TEMP &&
            9'(i_entry_index) < 9'(MAX_TEMP_POINTS)) begin
            tp_mem[i_entry_index[TPW-1:0]] <= i_entry_value;
        end
        r_tp_rd <= tp_mem[w_addr[TPW-1:0]];
    end

    // grid memories
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_action == ACT_WR_LIN && 13'(i_entry_index) < 13'(GRID_DEPTH)) begin
            lin_mem[GW'(i_entry_index)] <= i_entry_value;
        end
        r_lin_rd <= lin_mem[w_gaddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_action == ACT_WR_PAR && 13'(i_entry_index) < 13'(GRID_DEPTH)) begin
            par_mem[GW'(i_entry_index)] <= i_entry_value;
        end
        r_par_rd <= par_mem[w_gaddr];
    end

    assign w_rem_sh    = (r_dcnt == 5'd0) ? r_rem : {r_rem[32:0], 1'b0};
    assign w_base_full = BW'(r_nt) * BW'(r_ic) + BW'(r_it);
    assign w_st_full   = 34'(r_s) * 34'(r_t);

    always_comb begin
        w_g0 = r_gsel ? r_pv0 : r_lv0;
        w_g1 = r_gsel ? r_pv1 : r_lv1;
        w_g2 = r_gsel ? r_pv2 : r_lv2;
        w_g3 = r_gsel ? r_pv3 : r_lv3;
        case (r_term)
            2'd0: begin
                w_coef = r_s;
                w_diff = 34'(w_g1) - 34'(w_g0);
            end
            2'd1: begin
                w_coef = r_t;
                w_diff = 34'(w_g2) - 34'(w_g0);
            end
            default: begin
                w_coef = r_st;
                w_diff = 34'(w_g0) + 34'(w_g3) - 34'(w_g1) - 34'(w_g2);
            end
        endcase
    end

    assign w_rnd = 40'((r_acc + 56'sd32768) >>> 16);
    always_comb begin
        if (w_rnd > 40'sd2147483647) begin
            w_sat = 32'sh7FFF_FFFF;
        end else if (w_rnd < -40'sd2147483648) begin
            w_sat = 32'sh8000_0000;
        end else begin
            w_sat = w_rnd[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_pend   <= 1'b0;
            o_out_valid  <= 1'b0;
            r_cl_percent <= '0;
            r_cl_count   <= '0;
            r_temp_count <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_CL_PERCENT: r_cl_percent <= i_cfg_data;
                    REG_CL_COUNT:   r_cl_count   <= i_cfg_data[4:0];
                    REG_TEMP_COUNT: r_temp_count <= i_cfg_data[4:0];
                    default: ;
                endcase
            end

            // deliver a finished result once the output register is free
            if (r_out_pend && (!o_out_valid || w_out_acc)) begin
                o_out_valid        <= 1'b1;
                o_linear_factor    <= r_lin_res;
                o_parabolic_factor <= r_par_res;
                r_out_pend         <= 1'b0;
            end else if (w_out_acc) begin
                o_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && i_action == ACT_EVAL) begin
                        if (w_disabled) begin
                            r_lin_res  <= ONE_Q16;
                            r_par_res  <= ONE_Q16;
                            r_out_pend <= 1'b1;
                        end else begin
                            r_ph    <= 1'b0;
                            r_x     <= 33'(signed'({1'b0, r_cl_percent}));
                            r_n     <= w_nc;
                            r_nt    <= w_nt;
                            r_temp  <= i_temperature;
                            r_state <= S_LO;
                        end
                    end
                end
                S_LO: r_state <= S_HI;
                S_HI: begin
                    r_lo <= w_bdata;
                    if (r_x <= w_bdata) begin
                        r_idx   <= '0;
                        r_frac  <= '0;
                        r_state <= S_BDONE;
                    end else begin
                        r_state <= S_HIC;
                    end
                end
                S_HIC: begin
                    if (r_x >= w_bdata) begin
                        r_idx   <= w_nm2;
                        r_frac  <= FRAC_ONE;
                        r_state <= S_BDONE;
                    end else begin
                        r_k     <= IW'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_lo <= r_x && r_x <= w_bdata) begin
                        r_idx  <= r_k - IW'(1);
                        r_rem  <= 34'(r_x - r_lo);
                        r_den  <= 33'(w_bdata - r_lo);
                        r_frac <= '0;
                        r_dcnt <= '0;
                        // zero-width interval keeps fraction zero
                        r_state <= (w_bdata == r_lo) ? S_BDONE : S_DIV;
                    end else if (r_k == w_nm1) begin
                        r_idx   <= w_nm2;
                        r_frac  <= FRAC_ONE;
                        r_state <= S_BDONE;
                    end else begin
                        r_lo <= w_bdata;
                        r_k  <= r_k + IW'(1);
                    end
                end
                S_DIV: begin
                    if (w_rem_sh >= 34'(r_den)) begin
                        r_rem  <= w_rem_sh - 34'(r_den);
                        r_frac <= {r_frac[15:0], 1'b1};
                    end else begin
                        r_rem  <= w_rem_sh;
                        r_frac <= {r_frac[15:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt + 5'd1;
                    if (r_dcnt == 5'd16) begin
                        r_state <= S_BDONE;
                    end
                end
                S_BDONE: begin
                    if (!r_ph) begin
                        r_ic    <= r_idx;
                        r_s     <= r_frac;
                        r_ph    <= 1'b1;
                        r_x     <= 33'(r_temp);
                        r_n     <= r_nt;
                        r_state <= S_LO;
                    end else begin
                        r_it    <= r_idx;
                        r_t     <= r_frac;
                        r_state <= S_ADDR;
                    end
                end
                S_ADDR: begin
                    r_base0 <= GW'(w_base_full);
                    r_st    <= w_st_full[32:16];
                    r_state <= S_GA;
                end
                S_GA: r_state <= S_GB;
                S_GB: begin
                    r_lv0   <= r_lin_rd;
                    r_pv0   <= r_par_rd;
                    r_state <= S_GC;
                end
                S_GC: begin
                    r_lv2   <= r_lin_rd;
                    r_pv2   <= r_par_rd;
                    r_state <= S_GD;
                end
                S_GD: begin
                    r_lv1   <= r_lin_rd;
                    r_pv1   <= r_par_rd;
                    r_state <= S_GE;
                end
                S_GE: begin
                    r_lv3   <= r_lin_rd;
                    r_pv3   <= r_par_rd;
                    r_gsel  <= 1'b0;
                    r_term  <= 2'd0;
                    r_acc   <= 56'(r_lv0) <<< 16;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= $signed({1'b0, w_coef}) * w_diff;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc <= r_acc + 56'(r_prod);
                    if (r_term == 2'd2) begin
                        r_state <= S_RND;
                    end else begin
                        r_term  <= r_term + 2'd1;
                        r_state <= S_MUL;
                    end
                end
                S_RND: begin
                    if (!r_gsel) begin
                        r_lin_res <= w_sat;
                        r_gsel    <= 1'b1;
                        r_term    <= 2'd0;
                        r_acc     <= 56'(r_pv0) <<< 16;
                        r_state   <= S_MUL;
                    end else begin
                        r_par_res  <= w_sat;
                        r_out_pend <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

### sv/bti_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bti_checker
// Port-level checks of the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module bti_checker
    import bti_pkg::*;
(
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_in_valid,
    input wire               o_in_stall,
    input wire [2:0]         i_action,
    input wire               o_out_valid,
    input wire               i_out_stall,
    input wire signed [31:0] o_linear_factor,
    input wire signed [31:0] o_parabolic_factor
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_linear_factor)
            && $stable(o_parabolic_factor))
        else $error("stalled result changed");

    // an evaluate request blocks the next request
    a_eval_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_action == ACT_EVAL |=> o_in_stall)
        else $error("request accepted during evaluate");

    // a write request creates no result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_action != ACT_EVAL && !o_out_valid |=> !o_out_valid)
        else $error("result without evaluate");

    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind bilinear_table_interpolator bti_checker u_bti_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_stall         (o_in_stall),
    .i_action           (i_action),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_linear_factor    (o_linear_factor),
    .o_parabolic_factor (o_parabolic_factor)
);
`default_nettype wire

### sim/bilinear_table_interpolator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_table_interpolator_tb
// Loads breakpoint tables and factor grids, steps through chlorine and count
// settings, and checks every evaluate result against a bilinear predictor.
// ----------------------------------------------------------------------------
import bti_pkg::*;

class bti_scoreboard;
    logic signed [31:0] cl_bp[16];
    logic signed [31:0] temp_bp[16];
    logic signed [31:0] lin_grid[256];
    logic signed [31:0] par_grid[256];
    logic [22:0]        cl_pct;
    logic [4:0]         cl_cnt;
    logic [4:0]         temp_cnt;
    logic signed [31:0] lin_q[$];
    logic signed [31:0] par_q[$];
    int                 errors;

    function new();
        cl_pct   = 0;
        cl_cnt   = 0;
        temp_cnt = 0;
        errors   = 0;
    endfunction

    function void write_reg(t_reg_index idx, logic [22:0] data);
        case (idx)
            REG_CL_PERCENT: cl_pct = data;
            REG_CL_COUNT:   cl_cnt = data[4:0];
            REG_TEMP_COUNT: temp_cnt = data[4:0];
            default: ;
        endcase
    endfunction

    function void find_bracket(longint x, int n, bit use_temp, output int idx,
                               output longint frac);
        longint lo, hi, b0, bn;
        b0 = use_temp ? temp_bp[0] : cl_bp[0];
        bn = use_temp ? temp_bp[n-1] : cl_bp[n-1];
        idx  = n - 2;
        frac = 65536;
        if (x <= b0) begin
            idx  = 0;
            frac = 0;
            return;
        end
        if (x >= bn) return;
        for (int i = 0; i + 1 < n; i++) begin
            lo = use_temp ? temp_bp[i] : cl_bp[i];
            hi = use_temp ? temp_bp[i+1] : cl_bp[i+1];
            if (lo <= x && x <= hi) begin
                idx  = i;
                frac = (hi == lo) ? 0 : ((x - lo) * 65536) / (hi - lo);
                return;
            end
        end
    endfunction

    function logic signed [31:0] blend(bit parab, int b0, int b1, longint s,
                                       longint t, longint st);
        longint v0, v1, v2, v3, acc, r;
        v0 = parab ? par_grid[b0 % 256] : lin_grid[b0 % 256];
        v2 = parab ? par_grid[(b0 + 1) % 256] : lin_grid[(b0 + 1) % 256];
        v1 = parab ? par_grid[b1 % 256] : lin_grid[b1 % 256];
        v3 = parab ? par_grid[(b1 + 1) % 256] : lin_grid[(b1 + 1) % 256];
        acc = v0 * 65536 + s * (v1 - v0) + t * (v2 - v0) + st * (v0 + v3 - v1 - v2);
        r = (acc + 32768) >>> 16;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function void note_request(logic [2:0] act, logic [7:0] ix,
                               logic signed [31:0] val, logic signed [31:0] temp);
        int     nc, nt, ic, it;
        longint s, t, st;
        case (act)
            ACT_WR_CL:   if (ix < 16) cl_bp[ix] = val;
            ACT_WR_TEMP: if (ix < 16) temp_bp[ix] = val;
            ACT_WR_LIN:  lin_grid[ix] = val;
            ACT_WR_PAR:  par_grid[ix] = val;
            ACT_EVAL: begin
                nc = (cl_cnt > 16) ? 16 : cl_cnt;
                nt = (temp_cnt > 16) ? 16 : temp_cnt;
                if (cl_pct == 0 || nc < 2 || nt < 2) begin
                    lin_q.push_back(ONE_Q16);
                    par_q.push_back(ONE_Q16);
                end else begin
                    find_bracket(longint'(cl_pct), nc, 1'b0, ic, s);
                    find_bracket(longint'(temp), nt, 1'b1, it, t);
                    st = (s * t) / 65536;
                    lin_q.push_back(blend(1'b0, nt * ic + it, nt * (ic + 1) + it, s, t, st));
                    par_q.push_back(blend(1'b1, nt * ic + it, nt * (ic + 1) + it, s, t, st));
                end
            end
            default: ;
        endcase
    endfunction

    function void check_result(logic signed [31:0] lin, logic signed [31:0] par);
        logic signed [31:0] exp_lin, exp_par;
        if (lin_q.size() == 0) begin
            $display("%0t: unexpected result lin=%0d par=%0d", $time, lin, par);
            errors++;
            return;
        end
        exp_lin = lin_q.pop_front();
        exp_par = par_q.pop_front();
        if (lin !== exp_lin) begin
            $display("%0t: linear_factor expected %0d actual %0d", $time, exp_lin, lin);
            errors++;
        end
        if (par !== exp_par) begin
            $display("%0t: parabolic_factor expected %0d actual %0d", $time, exp_par, par);
            errors++;
        end
    endfunction
endclass

module bilinear_table_interpolator_tb;
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [2:0]         i_action = '0;
    logic [7:0]         i_entry_index = '0;
    logic signed [31:0] i_entry_value = '0;
    logic signed [31:0] i_temperature = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [31:0] o_linear_factor;
    logic signed [31:0] o_parabolic_factor;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = '0;
    logic [22:0]        i_cfg_data = '0;

    bti_scoreboard factor_board = new();
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;

    bilinear_table_interpolator u_dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            factor_board.check_result(o_linear_factor, o_parabolic_factor);
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_request(logic [2:0] act, logic [7:0] ix,
                                logic signed [31:0] val, logic signed [31:0] temp);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_entry_index <= ix;
        i_entry_value <= val;
        i_temperature <= temp;
        do @(posedge i_clk); while (o_in_stall);
        factor_board.note_request(act, ix, val, temp);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (factor_board.lin_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_index idx, logic [22:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        factor_board.write_reg(idx, data);
    endtask

    // shape: 0 ascending, 1 ascending with a repeated point, 2 unordered
    task automatic load_breakpoints(t_action act, int lo, int span, int shape);
        int pts[$];
        for (int i = 0; i < 16; i++) pts.push_back(lo + int'($urandom_range(span)));
        if (shape != 2) pts.sort();
        if (shape == 1) pts[5] = pts[4];
        for (int i = 0; i < 16; i++) send_request(act, i[7:0], pts[i], $urandom);
    endtask

    function automatic logic signed [31:0] pick_temp();
        int k;
        k = $urandom_range(15);
        case ($urandom_range(4))
            0: return $urandom;
            1: return factor_board.temp_bp[k];
            2: return factor_board.temp_bp[k] + $urandom_range(4000) - 2000;
            3: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return factor_board.temp_bp[0]
                     + $urandom_range(factor_board.temp_bp[15] - factor_board.temp_bp[0]);
        endcase
    endfunction

    initial begin
        logic [22:0] cl_choice;
        logic [2:0]  act;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // table disabled after reset, unused actions, ignored writes
        send_request(ACT_EVAL, 0, 0, 32'sh7fffffff);
        send_request(ACT_EVAL, 8'hff, 32'sh80000000, 32'sh80000000);
        send_request(3'd5, 8'hff, $urandom, $urandom);
        send_request(3'd6, 0, $urandom, $urandom);
        send_request(3'd7, 8'h55, $urandom, $urandom);
        send_request(ACT_WR_CL, 8'd16, $urandom, 0);
        send_request(ACT_WR_TEMP, 8'hff, $urandom, 0);

        // full load of both grids, mixing extremes and modest values
        for (int i = 0; i < 256; i++) begin
            send_request(ACT_WR_LIN, i[7:0], (i % 7 == 0) ? $urandom
                         : int'($urandom_range(400000)) - 200000, 0);
            send_request(ACT_WR_PAR, i[7:0], (i % 5 == 0) ? ((i % 2) ? 32'sh7fffffff
                         : 32'sh80000000) : int'($urandom_range(400000)), 0);
        end
        load_breakpoints(ACT_WR_CL, 0, 6553600, 1);
        load_breakpoints(ACT_WR_TEMP, -1000000, 3000000, 1);
        drain();

        // directed: counts below two, extremes of chlorine percent and temperature
        write_reg(REG_CL_PERCENT, 23'd1);
        write_reg(REG_CL_COUNT, 5'd1);
        write_reg(REG_TEMP_COUNT, 5'd16);
        send_request(ACT_EVAL, 0, 0, 0);
        drain();
        write_reg(REG_CL_COUNT, 5'd16);
        send_request(ACT_EVAL, 0, 0, 32'sh80000000);
        send_request(ACT_EVAL, 0, 0, 32'sh7fffffff);
        send_request(ACT_EVAL, 0, 0, factor_board.temp_bp[4]);
        send_request(ACT_EVAL, 0, 0, factor_board.temp_bp[7] + 1);
        drain();
        write_reg(REG_CL_PERCENT, 23'h7fffff);
        write_reg(REG_TEMP_COUNT, 5'd31);
        send_request(ACT_EVAL, 0, 0, factor_board.temp_bp[9]);
        drain();
        write_reg(REG_CL_PERCENT, 23'd6553600);
        write_reg(REG_CL_COUNT, 5'd2);
        write_reg(REG_TEMP_COUNT, 5'd2);
        send_request(ACT_EVAL, 0, 0, factor_board.temp_bp[0] + 7);
        send_request(ACT_EVAL, 0, 0, factor_board.temp_bp[1] - 7);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            load_breakpoints(ACT_WR_CL, -100000, 8500000, phase % 3);
            load_breakpoints(ACT_WR_TEMP, (phase == 5) ? -2000000000 : -5000000,
                             (phase == 5) ? 32'hee6b2800 : 20000000, (phase + 1) % 3);
            drain();
            case (phase)
                0: cl_choice = 23'd6553600;
                1: cl_choice = 23'h7fffff;
                2: cl_choice = factor_board.cl_bp[6][22:0];
                3: cl_choice = 23'd0;
                default: cl_choice = 23'($urandom);
            endcase
            write_reg(REG_CL_PERCENT, cl_choice);
            write_reg(REG_CL_COUNT, (phase == 3) ? 5'd0 : 5'($urandom_range(2, 31)));
            write_reg(REG_TEMP_COUNT, (phase == 6) ? 5'd16 : 5'($urandom_range(2, 31)));
            for (int n = 0; n < 60; n++) begin
                case ($urandom_range(19))
                    0, 1, 2: send_request(3'($urandom_range(ACT_WR_LIN, ACT_WR_PAR)),
                                          8'($urandom), $urandom, $urandom);
                    3: send_request(3'($urandom_range(5, 7)), 8'($urandom), $urandom,
                                    $urandom);
                    // breakpoint rewrites at random indices reuse values already in the tables
                    4: begin
                        act = 3'($urandom_range(ACT_WR_CL, ACT_WR_TEMP));
                        send_request(act, 8'($urandom), (act == ACT_WR_CL)
                                     ? factor_board.cl_bp[$urandom_range(15)]
                                     : factor_board.temp_bp[$urandom_range(15)], $urandom);
                    end
                    default: send_request(ACT_EVAL, 8'($urandom), $urandom, pick_temp());
                endcase
            end
            drain();
        end

        drain();
        if (factor_board.errors == 0 && factor_board.lin_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout at %0t", $time);
        $display("*** FAILED ***");
        $finish;
    end
endmodule

### filelist.f
sv/bti_pkg.sv
sv/bilinear_table_interpolator.sv
sv/bti_checker.sv
sim/bilinear_table_interpolator_tb.sv
